[rtl/core/npcm_pkg.sv]
// Shared types, constants and the distance function for the nearest palette colour match.
// No dependencies; every other file of the block imports this package.
package npcm_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int SLOT_LIMIT    = 256;
    localparam int CELL_COUNT    = (PALETTE_DEPTH < SLOT_LIMIT) ? PALETTE_DEPTH : SLOT_LIMIT;

    // field widths
    localparam int INDEX_W  = 8;
    localparam int COLOUR_W = 32;
    localparam int DIST_W   = 10;
    localparam int SIZE_W   = 9;

    // reset value of the palette size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

    typedef enum logic
    {
        KIND_LOAD  = 1'b0,
        KIND_MATCH = 1'b1
    } item_kind_t;

    // one beat travelling down the cell chain
    typedef struct packed
    {
        logic                valid;
        item_kind_t          kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [COLOUR_W-1:0] colour_word;
        logic [INDEX_W-1:0]  best_index;
        logic [DIST_W-1:0]   best_distance;
    } chain_beat_t;

    // sum of absolute differences over four signed bytes
    function automatic logic [DIST_W-1:0] l1_distance(
        input logic [COLOUR_W-1:0] a,
        input logic [COLOUR_W-1:0] b
    );
        logic signed [8:0] diff;
        logic [7:0]        mag;
        logic [8:0]        neg;
        logic [DIST_W-1:0] sum;
        sum = '0;
        for (int lane = 0; lane < 4; lane++)
        begin
            diff = $signed({a[8*lane+7], a[8*lane +: 8]})
                 - $signed({b[8*lane+7], b[8*lane +: 8]});
            neg  = 9'(-diff);
            mag  = diff[8] ? neg[7:0] : diff[7:0];
            sum  = sum + DIST_W'(mag);
        end
        return sum;
    endfunction

endpackage

[rtl/core/npcm_ifs.sv]
// Valid/ready channel interfaces of the nearest palette colour match.
// Depends on npcm_pkg for the field widths.

// item channel: palette loads and pixels
interface npcm_item_if;
    import npcm_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [COLOUR_W-1:0] colour_word;

    modport source (output valid, kind, entry_index, colour_word, input ready);
    modport sink   (input valid, kind, entry_index, colour_word, output ready);
endinterface

// result channel: nearest entry and its distance
interface npcm_result_if;
    import npcm_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;

    modport source (output valid, best_index, best_distance, input ready);
    modport sink   (input valid, best_index, best_distance, output ready);
endinterface

// configuration write channel: palette size
interface npcm_cfg_if;
    import npcm_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/npcm_cell.sv]
// One compare cell: holds a palette entry, writes it on a matching load beat and
// folds its distance into the running best of a pixel beat. Depends on npcm_pkg.
module npcm_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [npcm_pkg::INDEX_W-1:0]  slot_id,
    input  logic [npcm_pkg::SIZE_W-1:0]   used_size,
    input  npcm_pkg::chain_beat_t         beat_in,
    output npcm_pkg::chain_beat_t         beat_out
);
    import npcm_pkg::*;

    logic [COLOUR_W-1:0] colour_reg;
    chain_beat_t         beat_reg;
    chain_beat_t         beat_next;
    logic [DIST_W-1:0]   entry_distance;
    logic                in_use;
    logic                take;
    logic                load_hit;

    // distance and best-so-far update
    always_comb
    begin
        entry_distance = l1_distance(colour_reg, beat_in.colour_word);
        in_use    = {1'b0, slot_id} < used_size;
        take      = in_use && ((slot_id == '0) || (entry_distance < beat_in.best_distance));
        load_hit  = beat_in.valid && (beat_in.kind == KIND_LOAD)
                 && (beat_in.entry_index == slot_id);
        beat_next = beat_in;
        if (beat_in.valid && (beat_in.kind == KIND_MATCH) && take)
        begin
            beat_next.best_index    = slot_id;
            beat_next.best_distance = entry_distance;
        end
    end

    // palette entry storage
    always_ff @(posedge clk)
    begin
        if (advance && load_hit)
        begin
            colour_reg <= beat_in.colour_word;
        end
    end

    // beat register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (advance)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

[rtl/core/npcm_result_reg.sv]
// Output register at the end of the cell chain; also produces the chain advance.
// Depends on npcm_pkg.
module npcm_result_reg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  npcm_pkg::chain_beat_t         beat_in,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [npcm_pkg::INDEX_W-1:0]  best_index,
    output logic [npcm_pkg::DIST_W-1:0]   best_distance,
    output logic                          advance
);
    import npcm_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [INDEX_W-1:0] index_reg;
    logic [DIST_W-1:0]  dist_reg;

    // chain moves whenever the result slot is free or being taken
    always_comb
    begin
        advance    = !valid_reg || out_ready;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = beat_in.valid && (beat_in.kind == KIND_MATCH);
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg <= beat_in.best_index;
            dist_reg  <= beat_in.best_distance;
        end
    end

    assign out_valid     = valid_reg;
    assign best_index    = index_reg;
    assign best_distance = dist_reg;

endmodule

[rtl/core/nearest_palette_colour_match.sv]
// Nearest palette colour match: a chain of CELL_COUNT compare cells, one per palette entry.
// An accepted pixel passes through every cell's beat register and then the result register.
// Throughput: one item per cycle; the whole chain holds while the result register is full and not being taken.
// Loads travel the chain like pixels, so every pixel sees exactly the loads accepted before it.
// Reset: rst_n asynchronous active low; clears beat valids, sets palette size to 1.
// Palette entries are not cleared by reset and read as undefined until loaded.
module nearest_palette_colour_match
(
    input  logic           clk,
    input  logic           rst_n,
    npcm_item_if.sink      pix,
    npcm_result_if.source  res,
    npcm_cfg_if.sink       cfg
);
    import npcm_pkg::*;

    localparam logic [SIZE_W-1:0] CELL_LIMIT = SIZE_W'(CELL_COUNT);

    logic              advance;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [SIZE_W-1:0] used_size;
    chain_beat_t       chain [0:CELL_COUNT];

    // palette size register
    assign cfg.ready = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        if (cfg.valid)
        begin
            size_next = cfg.data;
        end
        used_size = (size_reg > CELL_LIMIT) ? CELL_LIMIT : size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // head of the chain: accepted beat with an empty best
    assign pix.ready = advance;

    always_comb
    begin
        chain[0].valid         = pix.valid && advance;
        chain[0].kind          = item_kind_t'(pix.kind);
        chain[0].entry_index   = pix.entry_index;
        chain[0].colour_word   = pix.colour_word;
        chain[0].best_index    = '0;
        chain[0].best_distance = '0;
    end

    // row of compare cells
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        npcm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .slot_id   (INDEX_W'(i)),
            .used_size (used_size),
            .beat_in   (chain[i]),
            .beat_out  (chain[i+1])
        );
    end

    // result register and chain stall
    npcm_result_reg u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat_in       (chain[CELL_COUNT]),
        .out_ready     (res.ready),
        .out_valid     (res.valid),
        .best_index    (res.best_index),
        .best_distance (res.best_distance),
        .advance       (advance)
    );

endmodule
